@@ design/slcfr_pkg.sv @@
// Package for the sync/length/checksum frame receiver.
// Holds the buffer sizing constants, operation codes and the structs shared
// by the control logic and the top level. No dependencies.
package slcfr_pkg;

    localparam int FRAME_CAPACITY = 128;
    localparam int BUF_ADDR_W     = $clog2(FRAME_CAPACITY);
    // The position can reach the capacity itself.
    localparam int POS_W          = $clog2(FRAME_CAPACITY + 1);
    // Wide enough for any position and any 8-bit byte value.
    localparam int CMP_W          = 9;

    localparam logic [7:0] SYNC_FIRST    = 8'h55;
    localparam logic [7:0] SYNC_SECOND   = 8'hAA;
    localparam logic [7:0] SUM_SEED      = 8'hFF;
    localparam logic [7:0] TIMEOUT_RESET = 8'd13;

    localparam int         PADDR_W          = 2;
    localparam logic [1:0] ADDR_IDLE_TIMEOUT = 2'd0;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef struct packed {
        logic                  wen;
        logic [BUF_ADDR_W-1:0] waddr;
        logic [7:0]            wdata;
        logic                  ren;
        logic [BUF_ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic       frame_ready;
        logic [7:0] byte_count;
        logic       read_ok;
        logic       checksum_fail;
        logic       timeout_drop;
        logic       overflow_drop;
    } status_t;

endpackage

@@ design/sync_length_checksum_frame_receiver.sv @@
// Top level of the sync/length/checksum frame receiver.
// Depends on slcfr_pkg, slcfr_ctrl and slcfr_ram.

// The receiver takes one beat per clock cycle on the slave stream while
// m_tready stays high, with no bubbles: an operation (tuser) of byte, tick,
// release or read, and it returns exactly one result beat for each input
// beat, in order. A result reaches the master stream through the registered
// read of the 128-byte frame buffer RAM and then the output register.
// Parsing state (position, checksum, length byte, idle timer, held flag) is
// updated in the cycle of acceptance, so a buffer read that follows a byte
// write sees the new data. Backpressure on the master side propagates
// combinationally to s_tready; as long as m_tready stays high, s_tready
// stays high. The idle timeout register (reset value 13) sits at APB byte
// address 0 and should be written only while the receiver is idle; a value
// of 0 disables the timer.
module sync_length_checksum_frame_receiver (
    input  logic                          clk,
    input  logic                          rst_n,
    // Slave stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // [7:0] data_byte, [14:8] read_index
    input  logic [1:0]                    s_tuser,  // [1:0] operation
    // Master stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] frame_ready, [8:1] byte_count, [16:9] read_data,
    // [17] checksum_fail, [18] timeout_drop, [19] overflow_drop
    output logic [23:0]                   m_tdata,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slcfr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic                       accept;
    logic                       s1_advance;
    logic                       s1_valid_reg, s1_valid_next;
    slcfr_pkg::status_t         s1_status_reg;
    logic                       s2_valid_reg, s2_valid_next;
    logic [23:0]                s2_data_reg;
    logic [7:0]                 idle_timeout_reg;
    logic [7:0]                 ram_rdata;
    logic [7:0]                 s1_read_data;
    slcfr_pkg::mem_req_t        mem_req;
    slcfr_pkg::status_t         status;

    // Configuration: a single register, written on the APB access phase.
    assign pready = 1'b1;
    assign prdata = (paddr == slcfr_pkg::ADDR_IDLE_TIMEOUT) ?
                    {24'd0, idle_timeout_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= slcfr_pkg::TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr == slcfr_pkg::ADDR_IDLE_TIMEOUT)
        begin
            idle_timeout_reg <= pwdata[7:0];
        end
    end

    // Two-stage pipeline: stage one waits for the RAM read data, stage two
    // is the output register. Each stage moves when the one after it is free.
    assign s1_advance    = !s2_valid_reg || m_tready;
    assign s_tready      = !s1_valid_reg || s1_advance;
    assign accept        = s_tvalid && s_tready;
    assign s1_valid_next = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = (s1_valid_reg && s1_advance) ? 1'b1 :
                           (m_tready ? 1'b0 : s2_valid_reg);

    slcfr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (slcfr_pkg::op_t'(s_tuser)),
        .data_byte    (s_tdata[7:0]),
        .read_index   (s_tdata[14:8]),
        .idle_timeout (idle_timeout_reg),
        .mem_req      (mem_req),
        .status       (status)
    );

    // The RAM holds its read data until the next read is issued, so a stall
    // in stage one keeps the data intact.
    slcfr_ram #(
        .WIDTH (8),
        .DEPTH (slcfr_pkg::FRAME_CAPACITY)
    ) u_frame_buffer (
        .clk   (clk),
        .we    (mem_req.wen),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.ren),
        .raddr (mem_req.raddr),
        .rdata (ram_rdata)
    );

    assign s1_read_data = s1_status_reg.read_ok ? ram_rdata : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status;
        end
        if (s1_valid_reg && s1_advance)
        begin
            s2_data_reg <= {4'd0,
                            s1_status_reg.overflow_drop,
                            s1_status_reg.timeout_drop,
                            s1_status_reg.checksum_fail,
                            s1_read_data,
                            s1_status_reg.byte_count,
                            s1_status_reg.frame_ready};
        end
    end

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = s2_data_reg;

endmodule

@@ design/slcfr_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module slcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/slcfr_ctrl.sv @@
// Frame parsing state: write position, running checksum, length byte,
// idle timer and held flag. Issues buffer writes and reads.
// Depends on slcfr_pkg.
module slcfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  slcfr_pkg::op_t      operation,
    input  logic [7:0]          data_byte,
    input  logic [6:0]          read_index,
    input  logic [7:0]          idle_timeout,
    output slcfr_pkg::mem_req_t mem_req,
    output slcfr_pkg::status_t  status
);

    logic [slcfr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                  sum_reg, sum_next;
    logic [7:0]                  idle_reg, idle_next;
    logic                        held_reg, held_next;
    logic [7:0]                  length_reg, length_next;
    logic [slcfr_pkg::POS_W-1:0] pos_inc;
    logic                        cfail;
    logic                        tdrop;
    logic                        ofl;

    always_comb
    begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        idle_next     = idle_reg;
        held_next     = held_reg;
        length_next   = length_reg;
        cfail         = 1'b0;
        tdrop         = 1'b0;
        ofl           = 1'b0;
        pos_inc       = pos_reg + 1'b1;
        mem_req.wen   = 1'b0;
        mem_req.waddr = slcfr_pkg::BUF_ADDR_W'(pos_reg);
        mem_req.wdata = data_byte;
        mem_req.ren   = 1'b0;
        mem_req.raddr = slcfr_pkg::BUF_ADDR_W'(read_index);

        if (accept)
        begin
            case (operation)
                slcfr_pkg::OP_BYTE:
                begin
                    if (!held_reg)
                    begin
                        idle_next = idle_timeout;
                        if (slcfr_pkg::CMP_W'(pos_reg) >=
                            slcfr_pkg::CMP_W'(slcfr_pkg::FRAME_CAPACITY))
                        begin
                            pos_next = '0;
                            ofl      = 1'b1;
                        end
                        else if (pos_reg == slcfr_pkg::POS_W'(0))
                        begin
                            if (data_byte == slcfr_pkg::SYNC_FIRST)
                            begin
                                mem_req.wen = 1'b1;
                                pos_next    = pos_inc;
                            end
                        end
                        else if (pos_reg == slcfr_pkg::POS_W'(1))
                        begin
                            mem_req.wen = 1'b1;
                            sum_next    = slcfr_pkg::SUM_SEED;
                            pos_next    = (data_byte == slcfr_pkg::SYNC_SECOND) ?
                                          pos_inc : '0;
                        end
                        else if (pos_reg == slcfr_pkg::POS_W'(2) ||
                                 pos_reg == slcfr_pkg::POS_W'(3))
                        begin
                            mem_req.wen = 1'b1;
                            sum_next    = sum_reg + data_byte;
                            pos_next    = pos_inc;
                            if (pos_reg == slcfr_pkg::POS_W'(3))
                            begin
                                length_next = data_byte;
                            end
                        end
                        else
                        begin
                            mem_req.wen = 1'b1;
                            pos_next    = pos_inc;
                            // The count reached the length byte: this is the checksum.
                            if (slcfr_pkg::CMP_W'(length_reg) ==
                                slcfr_pkg::CMP_W'(pos_inc))
                            begin
                                if (sum_reg == data_byte)
                                begin
                                    held_next = 1'b1;
                                end
                                else
                                begin
                                    pos_next = '0;
                                    cfail    = 1'b1;
                                end
                            end
                            else
                            begin
                                sum_next = sum_reg + data_byte;
                            end
                        end
                    end
                end
                slcfr_pkg::OP_TICK:
                begin
                    if (!held_reg)
                    begin
                        if (idle_reg == 8'd1)
                        begin
                            tdrop     = (pos_reg != '0);
                            pos_next  = '0;
                            idle_next = 8'd0;
                        end
                        else if (idle_reg > 8'd1)
                        begin
                            idle_next = idle_reg - 8'd1;
                        end
                    end
                end
                slcfr_pkg::OP_RELEASE:
                begin
                    if (held_reg)
                    begin
                        held_next = 1'b0;
                        pos_next  = '0;
                    end
                end
                slcfr_pkg::OP_READ:
                begin
                    mem_req.ren = 1'b1;
                end
                default:
                begin
                    mem_req.ren = 1'b0;
                end
            endcase
        end

        status.frame_ready   = held_next;
        status.byte_count    = 8'(pos_next);
        status.read_ok       = (operation == slcfr_pkg::OP_READ) &&
                               (slcfr_pkg::CMP_W'(read_index) <
                                slcfr_pkg::CMP_W'(slcfr_pkg::FRAME_CAPACITY));
        status.checksum_fail = cfail;
        status.timeout_drop  = tdrop;
        status.overflow_drop = ofl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            idle_reg <= '0;
            held_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            idle_reg <= idle_next;
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        length_reg <= length_next;
    end

endmodule
